### rtl/e2r_pkg.sv
// Package for the Euler ZYX to rotation matrix pipeline.
// Holds fixed-point constants, the CORDIC arctangent table and the Q30 multiply; no dependencies.
package e2r_pkg;
	localparam int FIELD_BITS   = 16;
	localparam int INT_FRAC     = 30;
	localparam int WORD_W       = 34;
	localparam int PROD_W       = 2 * WORD_W;
	localparam int DEF_ANGLE_W  = 16;
	localparam int DEF_COEF_W   = 16;
	localparam int DEF_STAGES   = 16;

	localparam logic signed [WORD_W-1:0] Q30_PI      = 34'sd3373259426;
	localparam logic signed [WORD_W-1:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [WORD_W-1:0] Q30_GAIN    = 34'sd652032874;

	function automatic logic signed [WORD_W-1:0] atan_q30(input int i);
		logic signed [WORD_W-1:0] r;
		begin
			unique case (i)
				0: r = 34'sd843314857;
				1: r = 34'sd497837829;
				2: r = 34'sd263043837;
				3: r = 34'sd133525159;
				4: r = 34'sd67021687;
				5: r = 34'sd33543516;
				6: r = 34'sd16775851;
				7: r = 34'sd8388437;
				8: r = 34'sd4194283;
				9: r = 34'sd2097149;
				default: r = (i < 31) ? (WORD_W'(64'sd1) <<< (30 - i)) : '0;
			endcase
			return r;
		end
	endfunction

	// Q30 product rounded half up back to Q30.
	function automatic logic signed [WORD_W-1:0] mulq(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [PROD_W-1:0] p;
		begin
			p = PROD_W'(a) * PROD_W'(b) + (PROD_W'(64'sd1) <<< (INT_FRAC - 1));
			return WORD_W'(p >>> INT_FRAC);
		end
	endfunction
endpackage

### rtl/euler_to_rotation_matrix.sv
// Euler ZYX angles to rotation matrix R = Rz(-yaw)*Ry(-pitch)*Rx(-roll), fully pipelined.
// Uses e2r_pkg for constants, the arctangent table and the Q30 multiply.
//
// Channels: s_axis carries one angle triple per beat, m_axis one matrix.
// s_axis_tdata: roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32].
// m_axis_tdata: r00..r22 row by row, 16 bits each, r00 in the low bits.
// Throughput: one beat per cycle unless the receiver stalls; every stage
// is a register with a valid bit. Stage 0 reduces angles to +-pi/2,
// CORDIC_STAGES stages (at most 32) run the three sine/cosine CORDICs in
// parallel, then two multiply stages and a sum stage form the entries, one
// stage rounds and a last stage saturates.
// When the receiver stalls, full stages hold (ready is high while any stage
// is free or the output register is draining), so nothing is lost or repeated;
// bubbles are squeezed out since each stage advances when the next one is free.
// Reset clears all valid bits; data registers are not reset.
module euler_to_rotation_matrix #(
	parameter int ANGLE_WIDTH   = e2r_pkg::DEF_ANGLE_W,
	parameter int COEF_WIDTH    = e2r_pkg::DEF_COEF_W,
	parameter int CORDIC_STAGES = e2r_pkg::DEF_STAGES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // roll, pitch, yaw
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata   // r00 r01 r02 r10 r11 r12 r20 r21 r22
);
	import e2r_pkg::*;

	localparam int NST   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int AW    = (ANGLE_WIDTH < FIELD_BITS) ? ANGLE_WIDTH : FIELD_BITS;
	localparam int AFRAC = ((ANGLE_WIDTH - 3) > INT_FRAC) ? INT_FRAC : (ANGLE_WIDTH - 3);
	localparam int CFRAC = ((COEF_WIDTH - 2) > INT_FRAC) ? INT_FRAC : (COEF_WIDTH - 2);
	localparam int SH    = INT_FRAC - CFRAC;
	localparam int NPIPE = NST + 6;

	typedef logic signed [WORD_W-1:0] w_t;

	// pipeline advance: stage k moves when stage k+1 is free or moving
	logic [NPIPE-1:0] vld_q;
	logic [NPIPE-1:0] adv;
	always_comb begin
		adv[NPIPE-1] = !vld_q[NPIPE-1] || m_axis_tready;
		for (int k = NPIPE - 2; k >= 0; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end
	assign s_axis_tready = adv[0];
	assign m_axis_tvalid = vld_q[NPIPE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= s_axis_tvalid;
			for (int k = 1; k < NPIPE; k++)
				if (adv[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// stage 0: scale to Q30, reduce by pi
	w_t z_in [3];
	w_t z_red [3];
	logic flip_c [3];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			z_in[a] = WORD_W'($signed(s_axis_tdata[16*a +: AW])) <<< (INT_FRAC - AFRAC);
			flip_c[a] = 1'b0;
			z_red[a] = z_in[a];
			if (z_in[a] > Q30_HALF_PI) begin
				z_red[a] = z_in[a] - Q30_PI;
				flip_c[a] = 1'b1;
			end else if (z_in[a] < -Q30_HALF_PI) begin
				z_red[a] = z_in[a] + Q30_PI;
				flip_c[a] = 1'b1;
			end
		end
	end

	w_t x_p [NST+1][3];
	w_t y_p [NST+1][3];
	w_t z_p [NST+1][3];
	logic f_p [NST+1][3];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int a = 0; a < 3; a++) begin
				x_p[0][a] <= Q30_GAIN;
				y_p[0][a] <= '0;
				z_p[0][a] <= z_red[a];
				f_p[0][a] <= flip_c[a];
			end
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv[i+1]) begin
				for (int a = 0; a < 3; a++) begin
					f_p[i+1][a] <= f_p[i][a];
					if (z_p[i][a] >= 0) begin
						x_p[i+1][a] <= x_p[i][a] - (y_p[i][a] >>> i);
						y_p[i+1][a] <= y_p[i][a] + (x_p[i][a] >>> i);
						z_p[i+1][a] <= z_p[i][a] - atan_q30(i);
					end else begin
						x_p[i+1][a] <= x_p[i][a] + (y_p[i][a] >>> i);
						y_p[i+1][a] <= y_p[i][a] - (x_p[i][a] >>> i);
						z_p[i+1][a] <= z_p[i][a] + atan_q30(i);
					end
				end
			end
		end
	end

	// sin/cos after flip
	w_t sr, cr, sp, cp, sy, cy;
	assign cr = f_p[NST][0] ? -x_p[NST][0] : x_p[NST][0];
	assign sr = f_p[NST][0] ? -y_p[NST][0] : y_p[NST][0];
	assign cp = f_p[NST][1] ? -x_p[NST][1] : x_p[NST][1];
	assign sp = f_p[NST][1] ? -y_p[NST][1] : y_p[NST][1];
	assign cy = f_p[NST][2] ? -x_p[NST][2] : x_p[NST][2];
	assign sy = f_p[NST][2] ? -y_p[NST][2] : y_p[NST][2];

	// product stage 1: two-factor products, keep sp, sr and cr
	w_t cysp_s1, sysp_s1, cycp_s1, sycr_s1, sysr_s1, sycp_s1, cycr_s1, cysr_s1;
	w_t cpsr_s1, cpcr_s1, sp_s1, sr_s1, cr_s1;
	always_ff @(posedge clk) begin
		if (adv[NST+1]) begin
			cysp_s1 <= mulq(cy, sp);
			sysp_s1 <= mulq(sy, sp);
			cycp_s1 <= mulq(cy, cp);
			sycr_s1 <= mulq(sy, cr);
			sysr_s1 <= mulq(sy, sr);
			sycp_s1 <= mulq(sy, cp);
			cycr_s1 <= mulq(cy, cr);
			cysr_s1 <= mulq(cy, sr);
			cpsr_s1 <= mulq(cp, sr);
			cpcr_s1 <= mulq(cp, cr);
			sp_s1   <= sp;
			sr_s1   <= sr;
			cr_s1   <= cr;
		end
	end

	// product stage 2: three-factor products
	w_t t1_s2, t2_s2, t4_s2, t5_s2;
	w_t cycp_s2, sycr_s2, sysr_s2, sycp_s2, cycr_s2, cysr_s2, cpsr_s2, cpcr_s2, sp_s2;
	always_ff @(posedge clk) begin
		if (adv[NST+2]) begin
			t1_s2 <= mulq(cysp_s1, sr_s1);
			t2_s2 <= mulq(cysp_s1, cr_s1);
			t4_s2 <= mulq(sysp_s1, sr_s1);
			t5_s2 <= mulq(sysp_s1, cr_s1);
			cycp_s2 <= cycp_s1; sycr_s2 <= sycr_s1; sysr_s2 <= sysr_s1;
			sycp_s2 <= sycp_s1; cycr_s2 <= cycr_s1; cysr_s2 <= cysr_s1;
			cpsr_s2 <= cpsr_s1; cpcr_s2 <= cpcr_s1; sp_s2 <= sp_s1;
		end
	end

	// sum stage 3
	w_t e_s3 [9];
	always_ff @(posedge clk) begin
		if (adv[NST+3]) begin
			e_s3[0] <= cycp_s2;
			e_s3[1] <= sycr_s2 + t1_s2;
			e_s3[2] <= sysr_s2 - t2_s2;
			e_s3[3] <= -sycp_s2;
			e_s3[4] <= cycr_s2 - t4_s2;
			e_s3[5] <= cysr_s2 + t5_s2;
			e_s3[6] <= sp_s2;
			e_s3[7] <= -cpsr_s2;
			e_s3[8] <= cpcr_s2;
		end
	end

	// stage 4: round to output fraction
	w_t rnd_s4 [9];
	always_ff @(posedge clk) begin
		if (adv[NST+4]) begin
			for (int e = 0; e < 9; e++)
				if (SH > 0)
					rnd_s4[e] <= (e_s3[e] + (w_t'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
				else
					rnd_s4[e] <= e_s3[e];
		end
	end

	// stage 5: saturate and pack
	localparam w_t LIM = w_t'(1) <<< CFRAC;
	logic [143:0] out_s5;
	always_ff @(posedge clk) begin
		if (adv[NST+5]) begin
			for (int e = 0; e < 9; e++) begin
				if (rnd_s4[e] > LIM)
					out_s5[16*e +: 16] <= LIM[15:0];
				else if (rnd_s4[e] < -LIM)
					out_s5[16*e +: 16] <= 16'(-LIM);
				else
					out_s5[16*e +: 16] <= rnd_s4[e][15:0];
			end
		end
	end
	assign m_axis_tdata = out_s5;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped under stall");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked while pipe has room");
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready && s_axis_tready |=> $countones(vld_q) <= NPIPE)
		else $error("valid count overflow");
`endif
endmodule
